// ===== rtl/fpt_pkg.sv =====
// Shared types and constants for the programmable-tap FIR filter.
// No dependencies; imported by every module of the block.
`default_nettype none

package fpt_pkg;

    // Filter length and data widths
    localparam int TAPS       = 128;
    localparam int SAMPLE_W   = 16;
    localparam int WEIGHT_W   = 16;
    localparam int INDEX_W    = 7;
    localparam int PROD_W     = SAMPLE_W + WEIGHT_W;
    localparam int RESULT_W   = 39;
    localparam int CNT_W      = (TAPS > 1) ? $clog2(TAPS) : 1;

    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(TAPS - 1);

    // Reset weight, about 0.01 in Q1.15
    localparam logic signed [WEIGHT_W-1:0] WEIGHT_RESET = 16'sd328;

    // Item kinds
    localparam logic KIND_SAMPLE = 1'b0;
    localparam logic KIND_WEIGHT = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DRAIN,
        ST_DONE
    } fpt_state_t;

    // Control broadcast to every tap cell
    typedef struct packed {
        logic shift;   // push a new sample in at the head
        logic rotate;  // circulate samples and weights one place toward the head
    } cell_ctrl_t;

    // Control of the multiply-accumulate unit
    typedef struct packed {
        logic clear;   // start a new sum
        logic enable;  // multiply the pair at the head this cycle
    } mac_ctrl_t;

endpackage

`default_nettype wire

// ===== rtl/fpt_tap_cell.sv =====
// One tap cell: holds one delay-line sample and one tap weight.
// Depends on fpt_pkg for widths, reset weight and the cell control struct.
`default_nettype none

module fpt_tap_cell
    import fpt_pkg::*;
(
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire cell_ctrl_t                 ctrl,
    input  wire logic                       load_en,
    input  wire logic signed [WEIGHT_W-1:0] weight_in,
    input  wire logic signed [SAMPLE_W-1:0] prev_sample,
    input  wire logic signed [SAMPLE_W-1:0] next_sample,
    input  wire logic signed [WEIGHT_W-1:0] next_weight,
    output logic signed [SAMPLE_W-1:0]      sample_out,
    output logic signed [WEIGHT_W-1:0]      weight_out
);

    logic signed [SAMPLE_W-1:0] sample_reg;
    logic signed [WEIGHT_W-1:0] weight_reg;

    // Shift on a new sample, circulate during the sum, load on a weight write
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sample_reg <= '0;
            weight_reg <= WEIGHT_RESET;
        end else begin
            if (ctrl.shift) begin
                sample_reg <= prev_sample;
            end else if (ctrl.rotate) begin
                sample_reg <= next_sample;
                weight_reg <= next_weight;
            end
            if (load_en) begin
                weight_reg <= weight_in;
            end
        end
    end

    assign sample_out = sample_reg;
    assign weight_out = weight_reg;

endmodule

`default_nettype wire

// ===== rtl/fpt_mac.sv =====
// Multiply-accumulate unit at the head of the tap ring.
// Depends on fpt_pkg for widths and the MAC control struct.
`default_nettype none

module fpt_mac
    import fpt_pkg::*;
(
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire mac_ctrl_t                  ctrl,
    input  wire logic signed [SAMPLE_W-1:0] sample,
    input  wire logic signed [WEIGHT_W-1:0] weight,
    output logic signed [RESULT_W-1:0]      acc
);

    logic signed [PROD_W-1:0]   prod_reg;
    logic                       prod_valid_reg;
    logic signed [RESULT_W-1:0] acc_reg;

    // Register the product, then add it in the next cycle
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prod_valid_reg <= 1'b0;
        end else begin
            prod_valid_reg <= ctrl.enable;
        end
    end

    always_ff @(posedge aclk) begin
        prod_reg <= sample * weight;
        if (ctrl.clear) begin
            acc_reg <= '0;
        end else if (prod_valid_reg) begin
            acc_reg <= acc_reg + {{(RESULT_W-PROD_W){prod_reg[PROD_W-1]}}, prod_reg};
        end
    end

    assign acc = acc_reg;

endmodule

`default_nettype wire

// ===== rtl/fir_filter_programmable_taps_unit.sv =====
// Top level of the programmable-tap FIR filter: tap ring, MAC and sequencer.
// Depends on fpt_pkg, fpt_tap_cell and fpt_mac.
`default_nettype none

// A sample transfer (kind 0) pushes the sample into a ring of TAPS cells, each
// holding one delayed sample and its tap weight. The ring then circulates one
// place per cycle past a single multiply-accumulate unit at its head until all
// TAPS taps have passed it; the unit sums weight k times the sample k steps back
// at full 39-bit precision. As the one multiplier is shared, the next item is
// taken only once the sum is done, after RUN, DRAIN and DONE; a result still
// waiting on m_ready holds the sequencer only when the next sum is ready. A
// weight transfer (kind 1) writes one tap and gives no result; an index at or
// above TAPS is dropped. After reset all samples are zero and all weights are
// 328 (Q1.15).
module fir_filter_programmable_taps_unit
    import fpt_pkg::*;
(
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       s_valid,
    output logic                            s_ready,
    input  wire logic                       s_kind,
    input  wire logic signed [SAMPLE_W-1:0] s_sample_value,
    input  wire logic [INDEX_W-1:0]         s_tap_index,
    input  wire logic signed [WEIGHT_W-1:0] s_tap_weight,
    output logic                            m_valid,
    input  wire logic                       m_ready,
    output logic signed [RESULT_W-1:0]      m_filtered_value
);

    fpt_state_t                 state_reg, state_next;
    logic [CNT_W-1:0]           cnt_reg, cnt_next;
    logic                       m_valid_reg, m_valid_next;
    logic signed [RESULT_W-1:0] m_data_reg;
    logic                       out_load;
    logic                       accept;
    logic                       load_weight;
    cell_ctrl_t                 cell_ctrl;
    mac_ctrl_t                  mac_ctrl;
    logic signed [RESULT_W-1:0] acc;

    logic signed [SAMPLE_W-1:0] cell_sample [TAPS];
    logic signed [WEIGHT_W-1:0] cell_weight [TAPS];

    assign accept      = s_valid && s_ready;
    assign load_weight = accept && (s_kind == KIND_WEIGHT);

    // Sequencer: next state and control
    always_comb begin
        state_next       = state_reg;
        cnt_next         = cnt_reg;
        m_valid_next     = m_valid_reg && !m_ready;
        out_load         = 1'b0;
        s_ready          = 1'b0;
        cell_ctrl.shift  = 1'b0;
        cell_ctrl.rotate = 1'b0;
        mac_ctrl.clear   = 1'b0;
        mac_ctrl.enable  = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid && s_kind == KIND_SAMPLE) begin
                    cell_ctrl.shift = 1'b1;
                    mac_ctrl.clear  = 1'b1;
                    cnt_next        = '0;
                    state_next      = ST_RUN;
                end
            end
            ST_RUN: begin
                cell_ctrl.rotate = 1'b1;
                mac_ctrl.enable  = 1'b1;
                cnt_next         = cnt_reg + 1'b1;
                if (cnt_reg == CNT_LAST) begin
                    cnt_next   = '0;
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    out_load     = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Hold the finished sum for the result transfer
    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_data_reg <= acc;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_filtered_value = m_data_reg;

    // Tap ring: cell 0 holds the newest sample and weight 0
    for (genvar k = 0; k < TAPS; k++) begin : g_cell
        logic load_en;
        assign load_en = load_weight && (int'(s_tap_index) == k);

        fpt_tap_cell u_cell (
            .aclk        (aclk),
            .aresetn     (aresetn),
            .ctrl        (cell_ctrl),
            .load_en     (load_en),
            .weight_in   (s_tap_weight),
            .prev_sample ((k == 0) ? s_sample_value : cell_sample[(k + TAPS - 1) % TAPS]),
            .next_sample (cell_sample[(k + 1) % TAPS]),
            .next_weight (cell_weight[(k + 1) % TAPS]),
            .sample_out  (cell_sample[k]),
            .weight_out  (cell_weight[k])
        );
    end

    fpt_mac u_mac (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (mac_ctrl),
        .sample  (cell_sample[0]),
        .weight  (cell_weight[0]),
        .acc     (acc)
    );

endmodule

`default_nettype wire

// ===== verif/tb_top.sv =====
// Self-checking testbench for the programmable-tap FIR filter.
// Needs fpt_pkg and the fir_filter_programmable_taps_unit RTL; nothing else.
// Drives sample and weight transfers and checks each 39-bit sum against a local predictor.
`default_nettype none

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import fpt_pkg::*;

    typedef struct {
        logic                       kind;
        logic signed [SAMPLE_W-1:0] sample;
        logic [INDEX_W-1:0]         idx;
        logic signed [WEIGHT_W-1:0] weight;
    } fir_item_t;

    // Clock, reset and DUT ports
    logic                       aclk           = 1'b0;
    logic                       aresetn        = 1'b0;
    logic                       s_valid        = 1'b0;
    logic                       s_ready;
    logic                       s_kind         = KIND_SAMPLE;
    logic signed [SAMPLE_W-1:0] s_sample_value = '0;
    logic [INDEX_W-1:0]         s_tap_index    = '0;
    logic signed [WEIGHT_W-1:0] s_tap_weight   = '0;
    logic                       m_valid;
    logic                       m_ready        = 1'b0;
    logic signed [RESULT_W-1:0] m_filtered_value;

    // Stimulus queue and idle percentages
    fir_item_t pending_items[$];
    int        send_idle_pct    = 0;
    int        ready_stall_pct  = 0;
    bit        item_taken       = 1'b0;

    // Predictor state: circular sample history and per-tap weights
    logic signed [SAMPLE_W-1:0] sample_ring [TAPS];
    logic signed [WEIGHT_W-1:0] tap_weight_mem [TAPS];
    int                         newest_slot;
    logic [RESULT_W-1:0]        expected_sums[$];

    // Run statistics
    int errors         = 0;
    int samples_sent   = 0;
    int weights_loaded = 0;
    int sums_checked   = 0;

    always #5 aclk = ~aclk;

    fir_filter_programmable_taps_unit u_dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_kind           (s_kind),
        .s_sample_value   (s_sample_value),
        .s_tap_index      (s_tap_index),
        .s_tap_weight     (s_tap_weight),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_filtered_value (m_filtered_value)
    );

    // Shift a sample into the history and return the 39-bit sum of products
    function automatic logic [RESULT_W-1:0] shift_and_sum(logic signed [SAMPLE_W-1:0] x);
        longint acc;
        int     slot;
        newest_slot = (newest_slot + 1) % TAPS;
        sample_ring[newest_slot] = x;
        acc  = 0;
        slot = newest_slot;
        for (int k = 0; k < TAPS; k++) begin
            acc += longint'(tap_weight_mem[k]) * longint'(sample_ring[slot]);
            slot = (slot == 0) ? TAPS - 1 : slot - 1;
        end
        return RESULT_W'(acc);
    endfunction

    task automatic add_sample(logic signed [SAMPLE_W-1:0] x);
        fir_item_t it;
        it.kind   = KIND_SAMPLE;
        it.sample = x;
        it.idx    = INDEX_W'($urandom);
        it.weight = WEIGHT_W'($urandom);
        pending_items.push_back(it);
    endtask

    task automatic add_weight(int idx, logic signed [WEIGHT_W-1:0] w);
        fir_item_t it;
        it.kind   = KIND_WEIGHT;
        it.sample = SAMPLE_W'($urandom);
        it.idx    = INDEX_W'(idx);
        it.weight = w;
        pending_items.push_back(it);
    endtask

    // Favor the corners of the 16-bit range, otherwise anything
    function automatic logic signed [15:0] pick_value();
        case ($urandom_range(9))
            0:       return 16'sh8000;
            1:       return 16'sh7fff;
            2:       return 16'sh0000;
            3:       return 16'shffff;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic add_random_items(int n);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(99) < 35) begin
                add_weight($urandom_range(TAPS - 1), pick_value());
            end else begin
                add_sample(pick_value());
            end
        end
    endtask

    // Hold until every queued item is taken and every sum has come back
    task automatic wait_drained();
        while (pending_items.size() != 0 || s_valid || expected_sums.size() != 0) begin
            @(posedge aclk);
        end
    endtask

    // Driver: change inputs on the falling edge
    always @(negedge aclk) begin : drive_proc
        fir_item_t nxt;
        if (!aresetn) begin
            s_valid <= 1'b0;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= ready_stall_pct);
            if (!s_valid || item_taken) begin
                item_taken = 1'b0;
                if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    nxt = pending_items.pop_front();
                    s_valid        <= 1'b1;
                    s_kind         <= nxt.kind;
                    s_sample_value <= nxt.sample;
                    s_tap_index    <= nxt.idx;
                    s_tap_weight   <= nxt.weight;
                end else begin
                    // idle: scramble the payload so stale data cannot be reused
                    s_valid        <= 1'b0;
                    s_kind         <= 1'($urandom);
                    s_sample_value <= SAMPLE_W'($urandom);
                    s_tap_index    <= INDEX_W'($urandom);
                    s_tap_weight   <= WEIGHT_W'($urandom);
                end
            end
        end
    end

    // Monitor: check results, then predict from the accepted input
    always @(posedge aclk) begin : monitor_proc
        logic [RESULT_W-1:0] want;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (expected_sums.size() == 0) begin
                    if (errors < 10) begin
                        $display("[%0t] ERROR: unexpected result %0d", $realtime,
                                 m_filtered_value);
                    end
                    errors++;
                end else begin
                    want = expected_sums.pop_front();
                    sums_checked++;
                    if (m_filtered_value !== want) begin
                        if (errors < 10) begin
                            $display("[%0t] ERROR: filtered_value expected %0d got %0d",
                                     $realtime, $signed(want), m_filtered_value);
                        end
                        errors++;
                    end
                end
            end
            if (s_valid && s_ready) begin
                item_taken = 1'b1;
                if (s_kind == KIND_WEIGHT) begin
                    weights_loaded++;
                    if (s_tap_index < TAPS) begin
                        tap_weight_mem[s_tap_index] = s_tap_weight;
                    end
                end else begin
                    samples_sent++;
                    expected_sums.push_back(shift_and_sum(s_sample_value));
                end
            end
        end
    end

    // Main sequence
    initial begin
        for (int i = 0; i < TAPS; i++) begin
            sample_ring[i]    = '0;
            tap_weight_mem[i] = WEIGHT_RESET;
        end
        newest_slot = 0;

        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Phase 1: bursty sender, slow receiver; directed corners first
        send_idle_pct   = 37;
        ready_stall_pct = 70;
        add_sample(16'sh7fff);
        add_sample(16'sh8000);
        add_sample(16'shffff);
        add_sample(16'sh0000);
        add_sample(16'sh0001);
        add_weight(0, 16'sh7fff);
        add_weight(TAPS - 1, 16'sh8000);
        add_weight(1, 16'sh0000);
        add_weight(7'b1010101, 16'shffff);
        add_weight(7'b0101010, 16'sh0001);
        add_sample(16'sh8000);
        add_sample(16'sh7fff);
        add_sample(16'sh5555);
        add_sample(16'shaaaa);
        add_weight(0, 16'sh8000);
        add_sample(16'sh8000);
        add_sample(16'sh7fff);
        add_weight(TAPS - 1, 16'sh7fff);
        add_weight(64, 16'sh5555);
        add_sample(16'sh0000);
        add_random_items(270);
        wait_drained();

        // Phase 2: slow sender, mostly ready receiver
        send_idle_pct   = 70;
        ready_stall_pct = 37;
        add_random_items(270);
        wait_drained();

        // Phase 3: no idling; drive the sum to its largest magnitudes
        send_idle_pct   = 0;
        ready_stall_pct = 0;
        for (int i = 0; i < TAPS; i++) add_weight(i, 16'sh8000);
        repeat (TAPS + 2) add_sample(16'sh8000);
        repeat (TAPS) add_sample(16'sh7fff);
        add_random_items(10);
        wait_drained();

        // Let any stray result show up
        repeat (2 * (TAPS + 3)) @(posedge aclk);
        if (expected_sums.size() != 0) begin
            $display("ERROR: %0d expected results never arrived", expected_sums.size());
            errors += expected_sums.size();
        end

        $display("Covered %0d sample transfers and %0d weight loads; %0d sums compared.",
                 samples_sent, weights_loaded, sums_checked);
        $display("Errors: %0d", errors);
        if (errors == 0) begin
            $display("fir_filter_programmable_taps_unit test passed");
        end else begin
            $display("fir_filter_programmable_taps_unit test failed");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #15_000_000;
        $display("Timeout waiting for the filter");
        $display("fir_filter_programmable_taps_unit test failed");
        $finish;
    end

endmodule

`default_nettype wire
